[rtl/cmpq_pkg.sv]
// Package: shared types and constants of the circular min-priority queue.
package cmpq_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int VAL_W     = 32;
    localparam int PRIO_W    = 14;

    localparam logic [PRIO_W-1:0] PRIO_FREE = 14'd9999;
    localparam logic [PRIO_W-1:0] PRIO_MAX  = 14'd9998;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [PRIO_W-1:0]       prio;
    } entry_t;

    typedef struct packed {
        logic   en;
        entry_t data;
    } wr_req_t;

endpackage

[rtl/cmpq_mem.sv]
// Slot table: one write port, one read port with registered read data.
module cmpq_mem #(
    parameter int DEPTH = cmpq_pkg::DEPTH_DEF,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  cmpq_pkg::wr_req_t wr,
    input  logic [IW-1:0]    waddr,
    input  logic [IW-1:0]    raddr,
    output cmpq_pkg::entry_t rdata
);

    cmpq_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[waddr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/circular_min_priority_queue.sv]
// Top level: circular min-priority queue with a sequential minimum scan over the slot table.
//
//  channel   signals                                      direction
//  request   in_valid, in_stall, action, item_value,      in (in_stall out)
//            item_priority
//  result    out_valid, out_stall, status, out_value,     out (out_stall in)
//            out_priority
//
// Enqueue and empty dequeue pass S_EXEC and S_DONE on the way to the result register.
// Dequeue of the last entry passes S_EXEC, S_HEAD and S_DONE. Other dequeues add S_SCAN
// before S_HEAD, one slot per cycle through the table's single read port.
// The next request can be taken in the cycle after the result register loads.
// Reset empties the queue at once; slot contents are masked by the pointers.
// One request at a time; a new one is accepted while a result waits on out_stall.
module circular_min_priority_queue #(
    parameter int DEPTH = cmpq_pkg::DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 action,
    input  logic signed [cmpq_pkg::VAL_W-1:0]    item_value,
    input  logic [cmpq_pkg::PRIO_W-1:0]          item_priority,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           status,
    output logic signed [cmpq_pkg::VAL_W-1:0]    out_value,
    output logic [cmpq_pkg::PRIO_W-1:0]          out_priority
);

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SCAN = 5'b00100,
        S_HEAD = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic act_reg, act_next;
    cmpq_pkg::entry_t req_reg, req_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic empty_reg, empty_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    cmpq_pkg::entry_t best_reg, best_next;
    cmpq_pkg::status_t res_status_reg, res_status_next;
    cmpq_pkg::entry_t res_reg, res_next;
    logic out_valid_reg, out_valid_next;
    cmpq_pkg::status_t out_status_reg, out_status_next;
    cmpq_pkg::entry_t out_reg, out_next;

    cmpq_pkg::wr_req_t wr;
    logic [IW-1:0] waddr;
    logic [IW-1:0] raddr;
    cmpq_pkg::entry_t rdata;
    logic [cmpq_pkg::PRIO_W-1:0] eff_prio;

    function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
        next_slot = (i == LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic occupied(input logic [IW-1:0] i, input logic [IW-1:0] h,
                                      input logic [IW-1:0] t);
        if (h <= t)
            occupied = (i >= h) && (i <= t);
        else
            occupied = (i >= h) || (i <= t);
    endfunction

    cmpq_mem #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_mem (
        .clk   (clk),
        .wr    (wr),
        .waddr (waddr),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign eff_prio = occupied(rd_idx_reg, head_reg, tail_reg) ? rdata.prio
                                                               : cmpq_pkg::PRIO_FREE;

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        req_next        = req_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        empty_next      = empty_reg;
        rd_idx_next     = rd_idx_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        res_status_next = res_status_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_next        = out_reg;
        wr              = '0;
        waddr           = '0;
        raddr           = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next      = action;
                    req_next.value = item_value;
                    req_next.prio = (item_priority > cmpq_pkg::PRIO_MAX) ? cmpq_pkg::PRIO_MAX
                                                                         : item_priority;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_status_next = cmpq_pkg::ST_OK;
                res_next.value  = '0;
                res_next.prio   = cmpq_pkg::PRIO_FREE;
                state_next      = S_DONE;
                if (act_reg == cmpq_pkg::ACT_ENQ)
                begin
                    if (empty_reg)
                    begin
                        wr.en      = 1'b1;
                        wr.data    = req_reg;
                        waddr      = '0;
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b0;
                    end
                    else if (next_slot(tail_reg) == head_reg)
                    begin
                        res_status_next = cmpq_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr.en     = 1'b1;
                        wr.data   = req_reg;
                        waddr     = next_slot(tail_reg);
                        tail_next = next_slot(tail_reg);
                    end
                end
                else
                begin
                    if (empty_reg)
                    begin
                        res_status_next = cmpq_pkg::ST_EMPTY;
                    end
                    else if (head_reg == tail_reg)
                    begin
                        raddr      = head_reg;
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        raddr       = '0;
                        rd_idx_next = '0;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (rd_idx_reg == '0 || eff_prio < best_reg.prio)
                begin
                    best_idx_next  = rd_idx_reg;
                    best_next.value = rdata.value;
                    best_next.prio = eff_prio;
                end
                if (rd_idx_reg == LAST)
                begin
                    raddr      = head_reg;
                    state_next = S_HEAD;
                end
                else
                begin
                    raddr       = rd_idx_reg + 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            S_HEAD:
            begin
                state_next = S_DONE;
                if (head_reg == tail_reg)
                begin
                    res_next   = rdata;
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b1;
                end
                else
                begin
                    res_next  = best_reg;
                    wr.en     = 1'b1;
                    wr.data   = rdata;
                    waddr     = best_idx_reg;
                    head_next = next_slot(head_reg);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_next        = res_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        req_reg        <= req_next;
        rd_idx_reg     <= rd_idx_next;
        best_idx_reg   <= best_idx_next;
        best_reg       <= best_next;
        res_status_reg <= res_status_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_reg        <= out_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign out_value    = out_reg.value;
    assign out_priority = out_reg.prio;

endmodule

[tb/sv/tb_circular_min_priority_queue.sv]
// Testbench for circular_min_priority_queue: directed table, then checked random requests.
`timescale 1ns / 1ps

module tb_circular_min_priority_queue;

    localparam int DEPTH = cmpq_pkg::DEPTH_DEF;
    localparam int VW = cmpq_pkg::VAL_W;
    localparam int PW = cmpq_pkg::PRIO_W;
    localparam int RAND_N = 1100;
    localparam int DIR_N = 23;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT = 400;
    localparam int QUIET_LO = 600;
    localparam int QUIET_HI = 800;
    localparam int DRAIN_CYCLES = 3 * (DEPTH + 4);

    typedef struct {
        cmpq_pkg::status_t    st;
        logic signed [VW-1:0] value;
        logic [PW-1:0]        prio;
    } result_t;

    typedef struct {
        logic                 act;
        logic signed [VW-1:0] value;
        logic [PW-1:0]        prio;
        bit                   typed;
        cmpq_pkg::status_t    st;
        logic signed [VW-1:0] rvalue;
        logic [PW-1:0]        rprio;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 action = cmpq_pkg::ACT_ENQ;
    logic signed [VW-1:0] item_value = '0;
    logic [PW-1:0]        item_priority = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           status;
    logic signed [VW-1:0] out_value;
    logic [PW-1:0]        out_priority;

    logic signed [VW-1:0] q_val [DEPTH];
    logic [PW-1:0]        q_pri [DEPTH];
    int                   q_head;
    int                   q_tail;
    bit                   q_is_empty;

    result_t pending_results [$];
    int      errors = 0;
    int      results_seen = 0;
    int      n_enq_ok = 0;
    int      n_deq_ok = 0;
    int      n_full = 0;
    int      n_empty = 0;
    bit      quiet_sender = 1'b0;

    dir_row_t dir_rows [DIR_N] = '{
        '{cmpq_pkg::ACT_DEQ, 32'sd0, 14'd0, 1'b1,
          cmpq_pkg::ST_EMPTY, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_ENQ, 32'sh7FFF_FFFF, 14'd0, 1'b1,
          cmpq_pkg::ST_OK, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_DEQ, 32'sd0, 14'd0, 1'b1,
          cmpq_pkg::ST_OK, 32'sh7FFF_FFFF, 14'd0},
        '{cmpq_pkg::ACT_ENQ, 32'sh8000_0000, 14'h3FFF, 1'b1,
          cmpq_pkg::ST_OK, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_DEQ, 32'sd0, 14'd0, 1'b1,
          cmpq_pkg::ST_OK, 32'sh8000_0000, cmpq_pkg::PRIO_MAX},
        '{cmpq_pkg::ACT_ENQ, 32'sd5, 14'd9998, 1'b1,
          cmpq_pkg::ST_OK, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_ENQ, -32'sd1, 14'd3, 1'b1,
          cmpq_pkg::ST_OK, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_ENQ, 32'sd0, 14'd3, 1'b1,
          cmpq_pkg::ST_OK, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_ENQ, 32'sd1, 14'd9999, 1'b1,
          cmpq_pkg::ST_OK, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_ENQ, 32'sd2, 14'd100, 1'b1,
          cmpq_pkg::ST_OK, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_ENQ, 32'sd3, 14'd7, 1'b1,
          cmpq_pkg::ST_OK, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_ENQ, 32'sd4, 14'd0, 1'b1,
          cmpq_pkg::ST_OK, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_ENQ, 32'sd6, 14'd12, 1'b1,
          cmpq_pkg::ST_OK, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_ENQ, 32'sd7, 14'd1, 1'b1,
          cmpq_pkg::ST_FULL, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_DEQ, 32'sd0, 14'd0, 1'b0,
          cmpq_pkg::ST_OK, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_DEQ, -32'sd1, 14'h3FFF, 1'b0,
          cmpq_pkg::ST_OK, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_DEQ, 32'sd0, 14'd0, 1'b0,
          cmpq_pkg::ST_OK, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_DEQ, 32'sd0, 14'd0, 1'b0,
          cmpq_pkg::ST_OK, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_DEQ, 32'sd0, 14'd0, 1'b0,
          cmpq_pkg::ST_OK, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_DEQ, 32'sd0, 14'd0, 1'b0,
          cmpq_pkg::ST_OK, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_DEQ, 32'sd0, 14'd0, 1'b0,
          cmpq_pkg::ST_OK, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_DEQ, 32'sd0, 14'd0, 1'b0,
          cmpq_pkg::ST_OK, 32'sd0, cmpq_pkg::PRIO_FREE},
        '{cmpq_pkg::ACT_DEQ, 32'sd0, 14'd0, 1'b1,
          cmpq_pkg::ST_EMPTY, 32'sd0, cmpq_pkg::PRIO_FREE}
    };

    circular_min_priority_queue #(
        .DEPTH(DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .item_value   (item_value),
        .item_priority(item_priority),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_value    (out_value),
        .out_priority (out_priority)
    );

    always #1 clk = ~clk;

    function automatic result_t serve_request(logic act, logic signed [VW-1:0] v,
                                              logic [PW-1:0] p);
        result_t       r;
        logic [PW-1:0] pc;
        int            best;
        r.st = cmpq_pkg::ST_OK;
        r.value = '0;
        r.prio = cmpq_pkg::PRIO_FREE;
        pc = (p > cmpq_pkg::PRIO_MAX) ? cmpq_pkg::PRIO_MAX : p;
        if (act == cmpq_pkg::ACT_ENQ)
        begin
            if (q_is_empty)
            begin
                q_head = 0;
                q_tail = 0;
                q_val[0] = v;
                q_pri[0] = pc;
                q_is_empty = 1'b0;
            end
            else if ((q_tail + 1) % DEPTH == q_head)
            begin
                r.st = cmpq_pkg::ST_FULL;
            end
            else
            begin
                q_tail = (q_tail + 1) % DEPTH;
                q_val[q_tail] = v;
                q_pri[q_tail] = pc;
            end
        end
        else if (q_is_empty)
        begin
            r.st = cmpq_pkg::ST_EMPTY;
        end
        else if (q_head == q_tail)
        begin
            r.value = q_val[q_head];
            r.prio = q_pri[q_head];
            q_val[q_head] = '0;
            q_pri[q_head] = cmpq_pkg::PRIO_FREE;
            q_head = 0;
            q_tail = 0;
            q_is_empty = 1'b1;
        end
        else
        begin
            best = 0;
            for (int i = 1; i < DEPTH; i++)
                if (q_pri[i] < q_pri[best])
                    best = i;
            r.value = q_val[best];
            r.prio = q_pri[best];
            q_val[best] = q_val[q_head];
            q_pri[best] = q_pri[q_head];
            q_val[q_head] = '0;
            q_pri[q_head] = cmpq_pkg::PRIO_FREE;
            q_head = (q_head + 1) % DEPTH;
        end
        case (r.st)
            cmpq_pkg::ST_FULL:  n_full++;
            cmpq_pkg::ST_EMPTY: n_empty++;
            default:
            begin
                if (act == cmpq_pkg::ACT_ENQ)
                    n_enq_ok++;
                else
                    n_deq_ok++;
            end
        endcase
        return r;
    endfunction

    task automatic send_request(input logic a, input logic signed [VW-1:0] v,
                                input logic [PW-1:0] p, input bit typed,
                                input result_t typed_res);
        result_t pred;
        while (!quiet_sender && $urandom_range(0, 99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= a;
        item_value <= v;
        item_priority <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = serve_request(a, v, p);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: status %0d value %0d prio %0d",
                       status, out_value, out_priority);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.st)
                begin
                    $error("status: expected %0d, got %0d", exp_r.st, status);
                    errors++;
                end
                if (out_value !== exp_r.value)
                begin
                    $error("out_value: expected %0d, got %0d", exp_r.value, out_value);
                    errors++;
                end
                if (out_priority !== exp_r.prio)
                begin
                    $error("out_priority: expected %0d, got %0d", exp_r.prio, out_priority);
                    errors++;
                end
            end
        end
    end

    // receiver: random stall, one long hold-off, one quiet stretch
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && results_seen >= HOLD_AT)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_done = 1'b1;
            end
            else if (results_seen >= QUIET_LO && results_seen < QUIET_HI)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 32);
        end
    end

    initial
    begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int                   enq_pct;
        int                   roll;
        logic                 a;
        logic signed [VW-1:0] v;
        logic [PW-1:0]        p;
        result_t              typed_res;
        result_t              none;

        for (int i = 0; i < DEPTH; i++)
        begin
            q_val[i] = '0;
            q_pri[i] = cmpq_pkg::PRIO_FREE;
        end
        q_head = 0;
        q_tail = 0;
        q_is_empty = 1'b1;
        none.st = cmpq_pkg::ST_OK;
        none.value = '0;
        none.prio = cmpq_pkg::PRIO_FREE;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
        begin
            typed_res.st = dir_rows[i].st;
            typed_res.value = dir_rows[i].rvalue;
            typed_res.prio = dir_rows[i].rprio;
            send_request(dir_rows[i].act, dir_rows[i].value, dir_rows[i].prio,
                         dir_rows[i].typed, typed_res);
        end

        enq_pct = 50;
        for (int i = 0; i < RAND_N; i++)
        begin
            quiet_sender = (i >= 500 && i < 700);
            // phases drive the queue toward full, toward empty, or hover
            if (i % 40 == 0)
            begin
                roll = int'($urandom_range(0, 2));
                enq_pct = (roll == 0) ? 15 : (roll == 1) ? 50 : 85;
            end
            a = ($urandom_range(0, 99) < enq_pct) ? cmpq_pkg::ACT_ENQ : cmpq_pkg::ACT_DEQ;
            roll = int'($urandom_range(0, 99));
            if (roll < 3)
                v = 32'sh7FFF_FFFF;
            else if (roll < 6)
                v = 32'sh8000_0000;
            else if (roll < 8)
                v = -32'sd1;
            else if (roll < 10)
                v = '0;
            else
                v = $signed($urandom);
            roll = int'($urandom_range(0, 99));
            if (roll < 10)
                p = PW'($urandom_range(9999, 16383));
            else if (roll < 40)
                p = PW'($urandom_range(0, 7));
            else
                p = PW'($urandom_range(0, 9998));
            send_request(a, v, p, 1'b0, none);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Covered %0d results: %0d enqueues, %0d dequeues, %0d full, %0d empty.",
                 results_seen, n_enq_ok, n_deq_ok, n_full, n_empty);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
